// ----- design/ssnd_pkg.sv -----
// shared types, constants and the segment decode for the four-digit display driver
// no dependencies
package ssnd_pkg;

    localparam logic [15:0] MAX_SHOWN = 16'd9999;
    localparam int          BIN_W     = 16;
    localparam int          DIG_W     = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [DIG_W-1:0] thousands;
        logic [DIG_W-1:0] hundreds;
        logic [DIG_W-1:0] tens;
        logic [DIG_W-1:0] ones;
    } t_digits;

    typedef struct packed {
        logic start;
        logic ovf;
    } t_emit_cmd;

    // bit0 is segment a; blank or non-decimal codes give all segments off
    function automatic logic [6:0] seg_pattern(input logic [DIG_W-1:0] digit,
                                               input logic blank);
        logic [6:0] pat;
        case (digit)
            4'd0:    pat = 7'h3f;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5b;
            4'd3:    pat = 7'h4f;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6d;
            4'd6:    pat = 7'h7d;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7f;
            4'd9:    pat = 7'h6f;
            default: pat = 7'h00;
        endcase
        return blank ? 7'h00 : pat;
    endfunction

endpackage

// ----- design/ssnd_bcd.sv -----
// bit-serial binary to bcd converter (shift and add-3), one input bit per cycle
// depends on ssnd_pkg
module ssnd_bcd (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ssnd_pkg::BIN_W-1:0]        i_value,
    output logic                              o_done,
    output ssnd_pkg::t_digits                 o_digits
);

    localparam int CNT_W = $clog2(ssnd_pkg::BIN_W);

    logic                        r_active;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [ssnd_pkg::BIN_W-1:0]  r_bin;
    logic [15:0]                 r_bcd;
    logic [15:0]                 n_adj;

    // each nibble is independent: add 3 where it would pass 9 after the shift
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                n_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                n_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ssnd_pkg::BIN_W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_active) begin
            r_bin <= {r_bin[ssnd_pkg::BIN_W-2:0], 1'b0};
            r_bcd <= {n_adj[14:0], r_bin[ssnd_pkg::BIN_W-1]};
        end
    end

    assign o_done   = r_done;
    assign o_digits = ssnd_pkg::t_digits'(r_bcd);

endmodule

// ----- design/ssnd_frame.sv -----
// frame sequencer: blanking, segment decode and one frame per cycle for each pass
// depends on ssnd_pkg
module ssnd_frame #(
    parameter int MAX_REFRESH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ssnd_pkg::t_emit_cmd                  i_cmd,
    input  logic [$clog2(MAX_REFRESH+1)-1:0]     i_passes,
    input  ssnd_pkg::t_digits                    i_digits,
    output logic                                 o_active,
    output logic                                 o_strobe,
    output logic [3:0]                           o_digit_select,
    output logic [6:0]                           o_segment_bits,
    output logic [11:0]                          o_shift_word,
    output logic                                 o_overflow_flag,
    output logic                                 o_last_frame
);

    localparam int PW = $clog2(MAX_REFRESH + 1);

    logic            r_active;
    logic [1:0]      r_k;
    logic [PW-1:0]   r_left;
    logic            r_ovf;
    logic [6:0]      r_seg [4];
    logic            r_strobe;
    logic [3:0]      r_sel;
    logic [6:0]      r_segs;
    logic            r_ovf_out;
    logic            r_last;

    logic            n_blank_th;
    logic            n_blank_hu;
    logic            n_blank_te;
    logic [3:0]      n_sel;
    logic            n_last;

    always_comb begin
        n_blank_th = (i_digits.thousands == '0);
        n_blank_hu = n_blank_th && (i_digits.hundreds == '0);
        n_blank_te = n_blank_hu && (i_digits.tens == '0);
        n_sel      = 4'b0001 << r_k;
        n_last     = (r_k == 2'd3) && (r_left == PW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
            r_k      <= '0;
            r_left   <= '0;
        end else begin
            r_strobe <= r_active;
            if (i_cmd.start) begin
                r_active <= 1'b1;
                r_k      <= '0;
                r_left   <= i_passes;
            end else if (r_active) begin
                r_k <= r_k + 1'b1;
                if (r_k == 2'd3) begin
                    r_left <= r_left - 1'b1;
                end
                if (n_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // frame order: ones, hundreds, tens, thousands
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ovf    <= i_cmd.ovf;
            r_seg[0] <= ssnd_pkg::seg_pattern(i_digits.ones, 1'b0);
            r_seg[1] <= ssnd_pkg::seg_pattern(i_digits.hundreds, n_blank_hu);
            r_seg[2] <= ssnd_pkg::seg_pattern(i_digits.tens, n_blank_te);
            r_seg[3] <= ssnd_pkg::seg_pattern(i_digits.thousands, n_blank_th);
        end
        r_sel     <= n_sel;
        r_segs    <= r_seg[r_k];
        r_ovf_out <= r_ovf;
        r_last    <= n_last;
    end

    assign o_active        = r_active;
    assign o_strobe        = r_strobe;
    assign o_digit_select  = r_sel;
    assign o_segment_bits  = r_segs;
    assign o_shift_word    = {r_sel, 1'b0, r_segs};
    assign o_overflow_flag = r_ovf_out;
    assign o_last_frame    = r_last && r_strobe;

endmodule

// ----- design/seven_segment_number_display.sv -----
// top level of the four-digit seven-segment display driver
// depends on ssnd_pkg, ssnd_bcd and ssnd_frame
//
// A request (number, refresh count) is taken when start is high and busy is low. The
// number is clamped to 9999 (o_overflow_flag marks this) and converted to four bcd digits
// by a shift-and-add-3 unit that takes one bit per cycle. Then each refresh
// pass gives four frames, one per cycle, in the order ones, hundreds, tens, thousands;
// the refresh count is clamped to MAX_REFRESH and a count of zero gives no frames. The
// block stays busy and takes no new request until the conversion and every pass are done.
// Each frame is on the outputs for exactly one cycle with o_strobe high and must be taken
// then; o_last_frame marks the final one.
module seven_segment_number_display #(
    parameter int MAX_REFRESH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_number_value,
    input  logic [4:0]  i_refresh_count,
    output logic        o_strobe,
    output logic [3:0]  o_digit_select,
    output logic [6:0]  o_segment_bits,
    output logic [11:0] o_shift_word,
    output logic        o_overflow_flag,
    output logic        o_last_frame
);

    localparam int PW = $clog2(MAX_REFRESH + 1);

    ssnd_pkg::t_state     r_state;
    ssnd_pkg::t_state     n_state;
    logic [PW-1:0]        r_passes;
    logic                 r_ovf;

    logic                 n_accept;
    logic                 n_over;
    logic [15:0]          n_value;
    logic [PW-1:0]        n_passes;
    logic                 conv_done;
    ssnd_pkg::t_digits    digits;
    ssnd_pkg::t_emit_cmd  emit_cmd;
    logic                 emit_active;

    always_comb begin
        n_over   = (i_number_value > ssnd_pkg::MAX_SHOWN);
        n_value  = n_over ? ssnd_pkg::MAX_SHOWN : i_number_value;
        if (i_refresh_count > 5'(MAX_REFRESH)) begin
            n_passes = PW'(MAX_REFRESH);
        end else begin
            n_passes = PW'(i_refresh_count);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssnd_pkg::S_IDLE: begin
                if (start) begin
                    n_state = ssnd_pkg::S_CONV;
                end
            end
            ssnd_pkg::S_CONV: begin
                if (conv_done) begin
                    n_state = (r_passes == '0) ? ssnd_pkg::S_IDLE : ssnd_pkg::S_EMIT;
                end
            end
            ssnd_pkg::S_EMIT: begin
                if (!emit_active) begin
                    n_state = ssnd_pkg::S_IDLE;
                end
            end
            default: n_state = ssnd_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        n_accept       = 1'b0;
        emit_cmd.start = 1'b0;
        emit_cmd.ovf   = r_ovf;
        busy           = 1'b1;
        case (r_state)
            ssnd_pkg::S_IDLE: begin
                busy     = 1'b0;
                n_accept = start;
            end
            ssnd_pkg::S_CONV: begin
                emit_cmd.start = conv_done && (r_passes != '0);
            end
            ssnd_pkg::S_EMIT: begin
                busy = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssnd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_passes <= n_passes;
            r_ovf    <= n_over;
        end
    end

    ssnd_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_accept),
        .i_value  (n_value),
        .o_done   (conv_done),
        .o_digits (digits)
    );

    ssnd_frame #(
        .MAX_REFRESH (MAX_REFRESH)
    ) u_frame (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (emit_cmd),
        .i_passes        (r_passes),
        .i_digits        (digits),
        .o_active        (emit_active),
        .o_strobe        (o_strobe),
        .o_digit_select  (o_digit_select),
        .o_segment_bits  (o_segment_bits),
        .o_shift_word    (o_shift_word),
        .o_overflow_flag (o_overflow_flag),
        .o_last_frame    (o_last_frame)
    );

    // frames only come out of the emit phase
    a_strobe_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ssnd_pkg::S_EMIT))
        else $error("frame strobe outside emit phase");

    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot(o_digit_select))
        else $error("digit select not one-hot");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after request");

    a_last_is_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_frame |-> o_strobe)
        else $error("last frame without strobe");

    a_emit_needs_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_cmd.start |-> (r_passes != '0))
        else $error("emit started with zero passes");

endmodule
